// ----- rtl/priority_event_queue_scheduler_assert.svh -----
// Assertion macros shared by the scheduler checker.
`ifndef PRIORITY_EVENT_QUEUE_SCHEDULER_ASSERT_SVH
`define PRIORITY_EVENT_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PEQS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PEQS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// ----- rtl/peqs_pkg.sv -----
// Shared constants, types and helpers of the priority event queue scheduler.
package peqs_pkg;

    localparam int NUM_LEVELS  = 8;
    localparam int QUEUE_SLOTS = 16;

    localparam int LEVEL_W = 3;
    localparam int EVENT_W = 8;
    localparam int READY_W = 8;
    localparam int LVL_IDX_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int SLOT_W    = $clog2(QUEUE_SLOTS);
    localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_SLOTS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [EVENT_W-1:0] event_t;
    typedef logic [ADDR_W-1:0]  addr_t;

    localparam logic FUNC_POST     = 1'b0;
    localparam logic FUNC_DISPATCH = 1'b1;

    // Controller commands to the datapath.
    typedef struct packed {
        logic exec;      // request accepted this cycle: update rings and state
        logic load_out;  // move the pending result into the output register
    } ctrl_cmd_t;

    // Advance a ring pointer with wrap.
    function automatic slot_t ring_next(input slot_t p);
        slot_t n;
        n = (p == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : p + 1'b1;
        return n;
    endfunction

    // Flat memory address of a slot in a level's ring.
    function automatic addr_t slot_addr(input logic [LVL_IDX_W-1:0] lv, input slot_t s);
        addr_t a;
        a = ADDR_W'(lv) * ADDR_W'(QUEUE_SLOTS) + ADDR_W'(s);
        return a;
    endfunction

endpackage

// ----- rtl/peqs_datapath.sv -----
// Datapath: ring pointers, ready bitmap, event memory and result register.
module peqs_datapath import peqs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  ctrl_cmd_t   cmd,
    input  logic        func,
    input  level_t      level,
    input  event_t      event_code,
    input  level_t      running_priority,
    output logic        granted,
    output level_t      grant_level,
    output event_t      grant_event,
    output logic        status,
    output logic [READY_W-1:0] ready_bits
);

    slot_t rp_reg [NUM_LEVELS];
    slot_t rp_next [NUM_LEVELS];
    slot_t wp_reg [NUM_LEVELS];
    slot_t wp_next [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] ready_map_reg, ready_map_next;

    event_t mem [MEM_DEPTH];
    event_t rdata_reg;

    logic   pend_granted_reg, pend_status_reg;
    level_t pend_level_reg;

    logic   out_granted_reg, out_status_reg;
    level_t out_level_reg;
    event_t out_event_reg;
    logic [READY_W-1:0] out_ready_reg;

    level_t top;
    level_t idx;
    logic [LVL_IDX_W-1:0] idx_i;
    logic   lvl_ok;
    slot_t  rp_sel, wp_sel, wp_adv, rp_adv;
    logic   full, empty, above;
    logic   post_ok, grant, clear_bit;

    // Priority encoder: highest ready level, level 0 when none.
    always_comb begin
        top = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (ready_map_reg[i]) begin
                top = LEVEL_W'(i);
            end
        end
    end

    assign lvl_ok = ({1'b0, level} < (LEVEL_W + 1)'(NUM_LEVELS));
    assign idx    = (func == FUNC_DISPATCH) ? top : level;
    assign idx_i  = idx[LVL_IDX_W-1:0];
    assign rp_sel = rp_reg[idx_i];
    assign wp_sel = wp_reg[idx_i];
    assign wp_adv = ring_next(wp_sel);
    assign rp_adv = ring_next(rp_sel);
    assign full   = (wp_adv == rp_sel);
    assign empty  = (rp_sel == wp_sel);
    assign above  = (top > running_priority);

    assign post_ok   = (func == FUNC_POST) && lvl_ok && !full;
    assign grant     = (func == FUNC_DISPATCH) && above && !empty;
    assign clear_bit = (func == FUNC_DISPATCH) && above && (empty || rp_adv == wp_sel);

    always_comb begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
            rp_next[i] = rp_reg[i];
            wp_next[i] = wp_reg[i];
        end
        ready_map_next = ready_map_reg;
        if (cmd.exec) begin
            if (post_ok) begin
                wp_next[idx_i] = wp_adv;
                ready_map_next[idx_i] = 1'b1;
            end
            if (grant) begin
                rp_next[idx_i] = rp_adv;
            end
            if (clear_bit) begin
                ready_map_next[idx_i] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                rp_reg[i] <= '0;
                wp_reg[i] <= '0;
            end
            ready_map_reg <= '0;
        end else begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                rp_reg[i] <= rp_next[i];
                wp_reg[i] <= wp_next[i];
            end
            ready_map_reg <= ready_map_next;
        end
    end

    // Event memory: one write or one registered read per request.
    always_ff @(posedge aclk) begin
        if (cmd.exec && post_ok) begin
            mem[slot_addr(idx_i, wp_adv)] <= event_code;
        end
        if (cmd.exec && grant) begin
            rdata_reg <= mem[slot_addr(idx_i, rp_adv)];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            pend_granted_reg <= grant;
            pend_level_reg   <= grant ? idx : '0;
            pend_status_reg  <= (func == FUNC_POST) && !post_ok;
        end
        if (cmd.load_out) begin
            out_granted_reg <= pend_granted_reg;
            out_level_reg   <= pend_level_reg;
            out_event_reg   <= pend_granted_reg ? rdata_reg : '0;
            out_status_reg  <= pend_status_reg;
            out_ready_reg   <= READY_W'(ready_map_reg);
        end
    end

    assign granted     = out_granted_reg;
    assign grant_level = out_level_reg;
    assign grant_event = out_event_reg;
    assign status      = out_status_reg;
    assign ready_bits  = out_ready_reg;

endmodule

// ----- rtl/peqs_controller.sv -----
// Controller: request acceptance, result hand-off and output valid.
module peqs_controller import peqs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output ctrl_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_OUT  = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/priority_event_queue_scheduler.sv -----
// Priority event queue scheduler: a 16-slot event ring per level with a ready
// bitmap. A post request (func 0) appends event_code to the ring of its level
// and sets that level's ready bit; a full ring (15 events, one slot stays free)
// or an out-of-range level drops the event and returns status 1. A dispatch
// request (func 1) picks the highest ready level; if it is strictly above
// running_priority, the oldest event of that level is popped and returned with
// granted 1, and the level's ready bit clears when its ring empties. Level 0 is
// never dispatched. Every request yields exactly one result, with ready_bits
// showing the bitmap after the request. In the accept cycle the pointers and
// bitmap update and the single-port event memory is written or read; once the
// output register is free, the registered read data moves into it and the
// controller goes idle. A new request is taken while a result waits at the
// output; a result stalled by m_ready holds the following request in ST_OUT
// until the output register frees up.
module priority_event_queue_scheduler import peqs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  level_t             s_level,
    input  event_t             s_event_code,
    input  level_t             s_running_priority,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_granted,
    output level_t             m_grant_level,
    output event_t             m_grant_event,
    output logic               m_status,
    output logic [READY_W-1:0] m_ready_bits
);

    ctrl_cmd_t cmd;

    // Sequence accept and result hand-off.
    peqs_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Hold rings, pointers and bitmap; compute each request's result.
    peqs_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .func             (s_func),
        .level            (s_level),
        .event_code       (s_event_code),
        .running_priority (s_running_priority),
        .granted          (m_granted),
        .grant_level      (m_grant_level),
        .grant_event      (m_grant_event),
        .status           (m_status),
        .ready_bits       (m_ready_bits)
    );

endmodule

// ----- rtl/peqs_checker.sv -----
// Port-level checker for the scheduler, bound to the top level.
`include "priority_event_queue_scheduler_assert.svh"

module peqs_checker import peqs_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_granted,
    input level_t             m_grant_level,
    input event_t             m_grant_event,
    input logic               m_status,
    input logic [READY_W-1:0] m_ready_bits
);

    `PEQS_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `PEQS_ASSERT_IMP(a_no_grant_zero, aclk, aresetn, m_valid && !m_granted, m_grant_level == '0 && m_grant_event == '0)
    `PEQS_ASSERT_IMP(a_grant_ok, aclk, aresetn, m_valid && m_granted, !m_status && m_grant_level != '0)
    `PEQS_ASSERT_NXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_grant_event) && $stable(m_ready_bits))

endmodule

bind priority_event_queue_scheduler peqs_checker u_peqs_checker (.*);
